// File: src/stfe_pkg.sv
package stfe_pkg;

  // Field and register widths
  localparam int PHASE_W   = 32;
  localparam int AMP_W     = 16;
  localparam int LEN_W     = 24;
  localparam int SAMPLE_W  = 16;
  localparam int SINE_W    = 15;
  localparam int ENV_W     = 16;
  localparam int IN_DATA_W = 8;

  // Envelope divider: quotient bits below 1.0 in Q1.15
  localparam int DIV_STEPS = 15;
  localparam int DIV_CNT_W = 4;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // Fixed-point constants
  localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;
  localparam logic [ENV_W-1:0] ENV_ONE = 16'h8000;
  localparam logic [63:0] PI_HALF_Q30  = 64'd1686629713;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
  localparam logic [63:0] Q29_HALF     = 64'd1 << 29;
  localparam logic [63:0] SINE_MAX     = 64'd32767;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_SAMPLE_COUNT = 2'd2,
    REG_FADE_LENGTH  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [AMP_W-1:0]   amplitude;
    logic [LEN_W-1:0]   sample_count;
    logic [LEN_W-1:0]   fade_length;
  } cfg_t;

endpackage

// File: src/stfe_fifo.sv
module stfe_fifo #(
  parameter int WIDTH = 57
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] mem [stfe_pkg::QUEUE_DEPTH];
  logic [stfe_pkg::QPTR_W-1:0] wr_ptr;
  logic [stfe_pkg::QPTR_W-1:0] rd_ptr;
  logic [stfe_pkg::QPTR_W:0]   fill;

  assign full      = (fill == (stfe_pkg::QPTR_W+1)'(stfe_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/stfe_front.sv
module stfe_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  stfe_pkg::cfg_t                          cfg,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [stfe_pkg::IN_DATA_W-1:0]          s_tdata,
  output logic                                    push,
  output logic [COUNT_BITS+stfe_pkg::PHASE_W:0]   push_data,
  input  logic                                    full
);

  logic [COUNT_BITS-1:0]        index;
  logic [COUNT_BITS-1:0]        index_next;
  logic [stfe_pkg::PHASE_W-1:0] phase;
  logic [stfe_pkg::PHASE_W-1:0] phase_next;

  logic [COUNT_BITS-1:0]        idx_cur;
  logic [stfe_pkg::PHASE_W-1:0] ph_cur;
  logic [COUNT_BITS-1:0]        count;
  logic [COUNT_BITS-1:0]        to_end;
  logic [COUNT_BITS-1:0]        m;
  logic                         take;
  logic                         active;
  logic                         is_last;

  assign s_tready = !full;

  // Classify the request: in-tone requests become jobs, the rest are dropped
  always_comb begin
    take    = s_tvalid && !full;
    idx_cur = s_tdata[0] ? '0 : index;
    ph_cur  = s_tdata[0] ? '0 : phase;
    count   = COUNT_BITS'(cfg.sample_count);
    if (count == '0) begin
      count = COUNT_BITS'(1);
    end
    active    = (idx_cur < count);
    to_end    = count - idx_cur;
    m         = (idx_cur < to_end) ? idx_cur : to_end;
    is_last   = ((idx_cur + COUNT_BITS'(1)) == count);
    push      = take && active;
    push_data = {is_last, m, ph_cur};

    index_next = index;
    phase_next = phase;
    if (take) begin
      if (active) begin
        index_next = idx_cur + COUNT_BITS'(1);
        phase_next = ph_cur + cfg.phase_step;
      end else begin
        index_next = idx_cur;
        phase_next = ph_cur;
      end
    end
  end

  // Hold tone position
  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
      phase <= '0;
    end else begin
      index <= index_next;
      phase <= phase_next;
    end
  end

endmodule

// File: src/stfe_back.sv
module stfe_back #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  stfe_pkg::cfg_t                        cfg,
  input  logic                                  q_valid,
  input  logic [COUNT_BITS+stfe_pkg::PHASE_W:0] q_data,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [stfe_pkg::SAMPLE_W-1:0]         m_tdata,
  output logic                                  m_tlast
);

  localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W     = SINE_TABLE_BITS + 1;
  localparam int DW        = (COUNT_BITS > stfe_pkg::LEN_W) ? COUNT_BITS : stfe_pkg::LEN_W;
  localparam int P1_W      = stfe_pkg::SINE_W + stfe_pkg::AMP_W;
  localparam int P2_W      = P1_W + stfe_pkg::ENV_W;

  typedef logic [stfe_pkg::SINE_W-1:0] rom_t [TABLE_LEN];

  // Quarter-wave table: Horner series of sin in Q2.30, rounded to Q0.15
  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] f;
    logic [63:0] s;
    logic [63:0] e;
    int          k;
    for (k = 0; k < TABLE_LEN; k++) begin
      x  = (64'(k) * stfe_pkg::PI_HALF_Q30) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      f  = stfe_pkg::Q30_ONE - x2 / 110;
      f  = stfe_pkg::Q30_ONE - ((x2 * f) >> 30) / 72;
      f  = stfe_pkg::Q30_ONE - ((x2 * f) >> 30) / 42;
      f  = stfe_pkg::Q30_ONE - ((x2 * f) >> 30) / 20;
      f  = stfe_pkg::Q30_ONE - ((x2 * f) >> 30) / 6;
      s  = (x * f) >> 30;
      e  = (s * stfe_pkg::SINE_MAX + stfe_pkg::Q29_HALF) >> 30;
      if (e > stfe_pkg::SINE_MAX) begin
        e = stfe_pkg::SINE_MAX;
      end
      t[k] = e[stfe_pkg::SINE_W-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_t;

  state_t                           state;
  logic [IDX_W-1:0]                 rom_addr;
  logic [stfe_pkg::SINE_W-1:0]      rom_q;
  logic                             neg;
  logic                             last_q;
  logic                             sat;
  logic [DW-1:0]                    rem;
  logic [stfe_pkg::DIV_STEPS-1:0]   quo;
  logic [stfe_pkg::DIV_CNT_W-1:0]   step_cnt;
  logic [P1_W-1:0]                  prod1;
  logic [P2_W-1:0]                  prod2;

  logic [stfe_pkg::PHASE_W-1:0]     j_phase;
  logic [COUNT_BITS-1:0]            j_m;
  logic                             j_last;
  logic [1:0]                       quad;
  logic [SINE_TABLE_BITS-1:0]       p;
  logic [IDX_W-1:0]                 idx;
  logic [DW-1:0]                    fade_eff;
  logic [DW-1:0]                    m_ext;
  logic [stfe_pkg::AMP_W-1:0]       amp_eff;
  logic [DW:0]                      rem2;
  logic [DW:0]                      rem_sub;
  logic                             ge;
  logic [stfe_pkg::ENV_W-1:0]       env;
  logic [stfe_pkg::SAMPLE_W-1:0]    mag;
  logic                             out_free;
  logic                             load_out;

  // Decode the job and set up operands
  always_comb begin
    j_phase  = q_data[stfe_pkg::PHASE_W-1:0];
    j_m      = q_data[stfe_pkg::PHASE_W +: COUNT_BITS];
    j_last   = q_data[COUNT_BITS+stfe_pkg::PHASE_W];
    quad     = j_phase[stfe_pkg::PHASE_W-1 -: 2];
    p        = j_phase[stfe_pkg::PHASE_W-3 -: SINE_TABLE_BITS];
    idx      = quad[0] ? (IDX_W'(1) << SINE_TABLE_BITS) - IDX_W'(p) : IDX_W'(p);
    fade_eff = DW'(cfg.fade_length);
    if (fade_eff == '0) begin
      fade_eff = DW'(1);
    end
    m_ext    = DW'(j_m);
    amp_eff  = (cfg.amplitude > stfe_pkg::AMP_ONE) ? stfe_pkg::AMP_ONE : cfg.amplitude;
    rem2     = {rem, 1'b0};
    ge       = (rem2 >= {1'b0, fade_eff});
    rem_sub  = rem2 - {1'b0, fade_eff};
    env      = sat ? stfe_pkg::ENV_ONE : {1'b0, quo};
    mag      = prod2[30 +: stfe_pkg::SAMPLE_W];
    out_free = !m_tvalid || m_tready;
    load_out = (state == ST_OUT) && out_free;
    q_pop    = (state == ST_IDLE) && q_valid;
  end

  // Table read, registered
  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  // Sequence one job: envelope divide, two multiplies, then the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Raise valid on a new sample, drop it once the sample is taken
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            rom_addr <= idx;
            neg      <= quad[1];
            last_q   <= j_last;
            sat      <= (m_ext >= fade_eff);
            rem      <= m_ext;
            quo      <= '0;
            step_cnt <= '0;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem      <= ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
          quo      <= {quo[stfe_pkg::DIV_STEPS-2:0], ge};
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == stfe_pkg::DIV_CNT_W'(stfe_pkg::DIV_STEPS - 1)) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod1 <= P1_W'(rom_q) * P1_W'(amp_eff);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2 <= P2_W'(prod1) * P2_W'(env);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata  <= neg ? (~mag + 1'b1) : mag;
            m_tlast  <= last_q;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/sine_tone_with_fade_envelope_unit.sv
// Sine tone generator with linear fade-in/fade-out. Each request on the slave
// stream is one tick: while the tone runs it yields one signed 16-bit sample
// (amplitude * envelope * sin(phase)), the final sample carrying tlast; once
// sample_count samples are out, ticks yield nothing until a request with
// restart set or sample_count is raised. The front end takes one request
// per cycle, while the queue is not full, into a two-entry job queue; the back
// end loads the job, runs the shift-subtract divider that forms the envelope
// (the table read overlaps it), does two multiplies and then loads the output
// register. It works on one job at a time and pops the next job only after
// the current sample is in the output register. Registers sit on an APB port
// at byte offsets 0x0 phase_step, 0x4 amplitude, 0x8 sample_count, 0xC
// fade_length, and are to be written only while no sample is pending.
module sine_tone_with_fade_envelope_unit #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int COUNT_BITS      = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stfe_pkg::IN_DATA_W-1:0] s_tdata,  // [0] restart, [7:1] zero
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [stfe_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] sample
  output logic                          m_tlast,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stfe_pkg::APB_AW-1:0]   paddr,
  input  logic [stfe_pkg::APB_DW-1:0]   pwdata,
  output logic [stfe_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int JOB_W = COUNT_BITS + stfe_pkg::PHASE_W + 1;

  stfe_pkg::cfg_t     cfg;
  stfe_pkg::reg_idx_t reg_sel;
  logic               wr_en;
  logic               push;
  logic [JOB_W-1:0]   push_data;
  logic               full;
  logic               pop;
  logic [JOB_W-1:0]   pop_data;
  logic               not_empty;

  assign pready  = 1'b1;
  assign reg_sel = stfe_pkg::reg_idx_t'(paddr[stfe_pkg::APB_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= stfe_pkg::PHASE_W'(1);
      cfg.amplitude    <= stfe_pkg::AMP_ONE;
      cfg.sample_count <= stfe_pkg::LEN_W'(1);
      cfg.fade_length  <= stfe_pkg::LEN_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        stfe_pkg::REG_PHASE_STEP:   cfg.phase_step   <= pwdata;
        stfe_pkg::REG_AMPLITUDE:    cfg.amplitude    <= pwdata[stfe_pkg::AMP_W-1:0];
        stfe_pkg::REG_SAMPLE_COUNT: cfg.sample_count <= pwdata[stfe_pkg::LEN_W-1:0];
        stfe_pkg::REG_FADE_LENGTH:  cfg.fade_length  <= pwdata[stfe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      stfe_pkg::REG_PHASE_STEP:   prdata = cfg.phase_step;
      stfe_pkg::REG_AMPLITUDE:    prdata = stfe_pkg::APB_DW'(cfg.amplitude);
      stfe_pkg::REG_SAMPLE_COUNT: prdata = stfe_pkg::APB_DW'(cfg.sample_count);
      stfe_pkg::REG_FADE_LENGTH:  prdata = stfe_pkg::APB_DW'(cfg.fade_length);
      default:                    prdata = '0;
    endcase
  end

  stfe_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  stfe_fifo #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  stfe_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (not_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: src/stfe_checker.sv
module stfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [stfe_pkg::SAMPLE_W-1:0] m_tdata,
  input logic                          m_tlast,
  input logic                          pready
);

  // Queue comes out of reset empty, so requests are taken at once
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_tready)
    else $error("s_tready low right after reset");

  // No sample is pending right after reset
  a_idle_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("m_tvalid high right after reset");

  // Samples are symmetric: the most negative code never appears
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata != 16'h8000))
    else $error("sample out of range");

  // A stalled sample holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled sample changed");

  // Register port never waits; checked while a stream request is offered
  a_pready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid |-> pready)
    else $error("pready low");

endmodule

bind sine_tone_with_fade_envelope_unit stfe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

// File: tb/sine_tone_with_fade_envelope_unit_test.sv
`timescale 1ns / 1ps

module sine_tone_with_fade_envelope_unit_test;
  import stfe_pkg::*;

  localparam int TABLE_BITS = 10;
  localparam int TABLE_TOP = 1 << TABLE_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned ENV_FULL = 64'd32768;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int TICK_TARGET = 1300;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic last;
  } tone_out_t;

  // Tone predictor and queue of samples still owed by the block
  class tone_scoreboard;
    int sine_rom[0:TABLE_TOP];
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0] amp;
    logic [LEN_W-1:0] count;
    logic [LEN_W-1:0] fade;
    logic [LEN_W-1:0] index;
    logic [PHASE_W-1:0] phase;
    tone_out_t owed[$];
    int mismatches;

    function new();
      longint unsigned x, x2, f, s, e;
      for (int k = 0; k <= TABLE_TOP; k++) begin
        x = (64'(k) * HALF_PI_Q30) >> TABLE_BITS;
        x2 = (x * x) >> 30;
        f = ONE_Q30 - x2 / 110;
        f = ONE_Q30 - ((x2 * f) >> 30) / 72;
        f = ONE_Q30 - ((x2 * f) >> 30) / 42;
        f = ONE_Q30 - ((x2 * f) >> 30) / 20;
        f = ONE_Q30 - ((x2 * f) >> 30) / 6;
        s = (x * f) >> 30;
        e = (s * 32767 + (64'd1 << 29)) >> 30;
        if (e > 32767) e = 32767;
        sine_rom[k] = int'(e);
      end
      step = 1;
      amp = AMP_ONE;
      count = 1;
      fade = 1;
      index = 0;
      phase = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t r, logic [APB_DW-1:0] v);
      case (r)
        REG_PHASE_STEP:   step = v[PHASE_W-1:0];
        REG_AMPLITUDE:    amp = v[AMP_W-1:0];
        REG_SAMPLE_COUNT: count = v[LEN_W-1:0];
        REG_FADE_LENGTH:  fade = v[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int sine_at(logic [PHASE_W-1:0] ph);
      int p, v;
      p = int'(ph[29:30-TABLE_BITS]);
      v = ph[30] ? sine_rom[TABLE_TOP - p] : sine_rom[p];
      return ph[31] ? -v : v;
    endfunction

    // Work out the sample a tick produces, if any, and advance the tone
    function void note_tick(bit restart);
      longint unsigned cnt, fd, gain, m, env, mag;
      int s;
      tone_out_t o;
      if (restart) begin
        index = 0;
        phase = 0;
      end
      cnt = (count == 0) ? 1 : count;
      if (index >= cnt) return;
      fd = (fade == 0) ? 1 : fade;
      gain = (amp > AMP_ONE) ? 64'(AMP_ONE) : 64'(amp);
      m = cnt - index;
      if (index < m) m = index;
      env = (m << 15) / fd;
      if (env > ENV_FULL) env = ENV_FULL;
      s = sine_at(phase);
      mag = (64'((s < 0) ? -s : s) * gain * env) >> 30;
      o.sample = (s < 0) ? -16'(mag) : 16'(mag);
      o.last = (64'(index) + 1 == cnt);
      owed.push_back(o);
      index = index + 1;
      phase = phase + step;
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic last);
      tone_out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: sample %0d last %0b arrived with nothing owed",
                   $realtime, $signed(sample), last);
        return;
      end
      want = owed.pop_front();
      if (sample !== want.sample || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: sample %0d last %0b, expected sample %0d last %0b",
                   $realtime, $signed(sample), last, $signed(want.sample), want.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;  // [0] restart, [7:1] zero
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;        // [15:0] sample
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tone_scoreboard tones = new();
  int cyc = 0;
  int quiet = 0;
  int ticks_sent = 0;
  int hold_left = 0;
  bit hold_ask = 1'b0;
  logic calm;

  // No random stalls on either side inside this window
  assign calm = (cyc >= 6000 && cyc < 12000);

  sine_tone_with_fade_envelope_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drain samples; stall at random or hold off for a long stretch on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) tones.check_sample(m_tdata, m_tlast);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    cyc++;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("sine_tone_with_fade_envelope_unit regression: fail");
      $finish;
    end
  end

  // Offer one tick request and wait for it to be taken
  task automatic send_tick(bit restart);
    if (!calm && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-1){1'b0}}, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tones.note_tick(restart);
    ticks_sent++;
  endtask

  task automatic send_ticks(int n, bit first_restart);
    for (int i = 0; i < n; i++) send_tick(first_restart && i == 0);
  endtask

  // Drop the request line and let every owed sample come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tones.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [APB_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tones.write_reg(r, v);
  endtask

  task automatic set_tone(logic [31:0] step, logic [15:0] amp, logic [23:0] cnt,
                          logic [23:0] fd);
    drain();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_AMPLITUDE, 32'(amp));
    write_reg(REG_SAMPLE_COUNT, 32'(cnt));
    write_reg(REG_FADE_LENGTH, 32'(fd));
  endtask

  // One random configuration followed by a burst of ticks
  task automatic random_phase(bit hold);
    logic [31:0] step;
    logic [15:0] amp;
    logic [23:0] cnt, fd;
    int pick, n, rate_div;
    pick = $urandom_range(99);
    if (pick < 10) step = 0;
    else if (pick < 20) step = 32'hFFFF_FFFF;
    else if (pick < 30) step = 32'd1 << $urandom_range(31);
    else step = $urandom;
    pick = $urandom_range(99);
    if (pick < 15) amp = AMP_ONE;
    else if (pick < 25) amp = 0;
    else if (pick < 35) amp = 16'($urandom_range(32769, 65535));
    else amp = 16'($urandom_range(32768));
    pick = $urandom_range(99);
    if (hold) cnt = 60;
    else if (pick < 70) cnt = 24'($urandom_range(1, 60));
    else if (pick < 80) cnt = 0;
    else cnt = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(2))
        0: rate_div = 80;
        1: rate_div = 441;
        default: rate_div = 480;
      endcase
      fd = (cnt / 10 < rate_div) ? cnt / 10 : 24'(rate_div);
      if (fd == 0) fd = 1;
    end else if (pick < 75) fd = 0;
    else if (pick < 90) fd = 24'($urandom_range(int'(cnt)));
    else fd = 24'($urandom);
    set_tone(step, amp, cnt, fd);

    pick = $urandom_range(99);
    if (hold || pick < 70) begin
      // Tone from a restart, whole when at most 60 samples, with up to two ticks past it
      if (hold) hold_ask = 1'b1;
      n = (cnt == 0) ? 1 : ((cnt > 60) ? 60 : int'(cnt));
      send_ticks(n + $urandom_range(2), 1'b1);
    end else if (pick < 85) begin
      send_ticks($urandom_range(1, 30), 1'b0);
    end else begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) send_tick($urandom_range(9) == 0);
    end
  endtask

  initial begin
    int phases;
    phases = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: single-sample tone, then silence, then restart
    send_ticks(2, 1'b0);
    send_tick(1'b1);

    // Quarter-turn steps hit the table ends; amplitude above one, zero fade
    set_tone(32'h4000_0000, 16'hFFFF, 24'd8, 24'd0);
    send_ticks(9, 1'b1);

    // Zero step, zero amplitude, zero count, widest fade
    set_tone(32'd0, 16'd0, 24'd0, 24'hFF_FFFF);
    send_ticks(2, 1'b1);

    // Widest step and count
    set_tone(32'hFFFF_FFFF, AMP_ONE, 24'hFF_FFFF, 24'd1);
    send_ticks(3, 1'b1);

    // Shrink the count below the index, then raise it so the tone goes on
    set_tone(32'hFFFF_FFFF, AMP_ONE, 24'd2, 24'd1);
    send_ticks(2, 1'b0);
    set_tone(32'h1234_5678, 16'h7FFF, 24'd6, 24'd2);
    send_ticks(4, 1'b0);

    while (ticks_sent < TICK_TARGET) begin
      random_phase(phases == 5);
      phases++;
    end

    drain();
    if (tones.mismatches == 0)
      $display("sine_tone_with_fade_envelope_unit regression: pass");
    else
      $display("sine_tone_with_fade_envelope_unit regression: fail");
    $finish;
  end

endmodule
